// ----- src/prefix_varint_encoder_defines.svh -----
// assertion macros for the prefix varint encoder
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef PREFIX_VARINT_ENCODER_DEFINES_SVH
`define PREFIX_VARINT_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked at every rising clock edge out of reset
`define PVE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prefix varint encoder check failed");
// next-cycle implication
`define PVE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prefix varint encoder check failed");
`else
`define PVE_ASSERT_NOW(label, clk, rst, ante, cons)
`define PVE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- src/pve_pkg.sv -----
// shared types and constants of the prefix varint encoder
// no dependencies
package pve_pkg;

   localparam int unsigned WordW      = 72;
   localparam int unsigned NumBytesW  = 4;
   localparam int unsigned QueueDepth = 2;

   localparam logic [7:0] PrefixWord = 8'he1;
   localparam logic [7:0] PrefixLong = 8'he2;

   localparam logic [NumBytesW-1:0] NumShort = 4'd1;
   localparam logic [NumBytesW-1:0] NumMid   = 4'd2;
   localparam logic [NumBytesW-1:0] NumTri   = 4'd3;
   localparam logic [NumBytesW-1:0] NumWord  = 4'd5;
   localparam logic [NumBytesW-1:0] NumLong  = 4'd9;

   localparam logic func_unsigned = 1'b0;

   typedef struct packed {
      logic        func;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   // one classified item: encoded bytes left-justified, msb first
   typedef struct packed {
      logic [WordW-1:0]     word;
      logic [NumBytesW-1:0] nbytes;
   } ent_type;

   typedef struct packed {
      logic valid;
      logic full;
   } qstat_type;

endpackage

// ----- src/pve_front.sv -----
// front end: accepts input items and picks the encoding class
// depends on pve_pkg
module pve_front (
   input  logic             req_valid,
   output logic             req_ready,
   input  pve_pkg::req_type req_item,
   input  logic             q_full,
   output logic             push,
   output pve_pkg::ent_type push_ent
);

   logic [63:0] v;
   logic        fit1, fit2, fit3, fit4;

   assign v = req_item.value;

   always_comb begin
      if (req_item.func == pve_pkg::func_unsigned) begin
         fit1 = (v[63:7] == '0);
         fit2 = (v[63:14] == '0);
         fit3 = (v[63:21] == '0);
         fit4 = (v[63:32] == '0);
      end else begin
         // sign-extension range checks
         fit1 = (v[63:6] == '0) || (v[63:6] == '1);
         fit2 = (v[63:13] == '0) || (v[63:13] == '1);
         fit3 = (v[63:20] == '0) || (v[63:20] == '1);
         fit4 = (v[63:31] == '0) || (v[63:31] == '1);
      end
   end

   always_comb begin
      push_ent = '0;
      priority if (fit1) begin
         push_ent.word   = {1'b0, v[6:0], 64'd0};
         push_ent.nbytes = pve_pkg::NumShort;
      end else if (fit2) begin
         push_ent.word   = {2'b10, v[13:0], 56'd0};
         push_ent.nbytes = pve_pkg::NumMid;
      end else if (fit3) begin
         push_ent.word   = {3'b110, v[20:0], 48'd0};
         push_ent.nbytes = pve_pkg::NumTri;
      end else if (fit4) begin
         push_ent.word   = {pve_pkg::PrefixWord, v[31:0], 32'd0};
         push_ent.nbytes = pve_pkg::NumWord;
      end else begin
         push_ent.word   = {pve_pkg::PrefixLong, v};
         push_ent.nbytes = pve_pkg::NumLong;
      end
   end

   assign req_ready = !q_full;
   assign push      = req_valid && req_ready;

endmodule

// ----- src/pve_fifo.sv -----
// short queue of classified items between front and back end
// depends on pve_pkg
module pve_fifo #(
   parameter int unsigned DEPTH = pve_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pve_pkg::ent_type    push_ent,
   input  logic                pop,
   output pve_pkg::ent_type    pop_ent,
   output pve_pkg::qstat_type  stat
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   pve_pkg::ent_type mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign stat.valid = (cnt_ff != '0);
   assign stat.full  = (cnt_ff == CntW'(DEPTH));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && stat.valid;
   assign pop_ent    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_ent;
      end
   end

endmodule

// ----- src/pve_back.sv -----
// back end: shifts the encoded bytes out through the output register
// depends on pve_pkg
module pve_back (
   input  logic               clock,
   input  logic               reset,
   input  pve_pkg::qstat_type q_stat,
   input  pve_pkg::ent_type   q_ent,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pve_pkg::rsp_type   rsp_item
);

   logic                             busy_ff, busy_in;
   logic [pve_pkg::WordW-1:0]        word_ff, word_in;
   logic [pve_pkg::NumBytesW-1:0]    left_ff, left_in;
   logic                             on_last;

   assign on_last = (left_ff == pve_pkg::NumShort);
   assign pop     = q_stat.valid && (!busy_ff || (rsp_ready && on_last));

   always_comb begin
      busy_in = busy_ff;
      word_in = word_ff;
      left_in = left_ff;
      if (busy_ff && rsp_ready) begin
         if (on_last) begin
            busy_in = 1'b0;
         end else begin
            word_in = {word_ff[pve_pkg::WordW-9:0], 8'h00};
            left_in = left_ff - 1'b1;
         end
      end
      if (pop) begin
         busy_in = 1'b1;
         word_in = q_ent.word;
         left_in = q_ent.nbytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      left_ff <= left_in;
   end

   assign rsp_valid          = busy_ff;
   assign rsp_item.out_byte  = word_ff[pve_pkg::WordW-1 -: 8];
   assign rsp_item.last_byte = on_last;

endmodule

// ----- src/prefix_varint_encoder.sv -----
// top level of the prefix-length varint encoder (64-bit values)
// depends on pve_pkg, pve_front, pve_fifo, pve_back and the defines header
//
// usage
//  - req channel: one transfer carries a 64-bit value and a format bit
//    (0 unsigned, 1 signed two's complement)
//  - rsp channel: one transfer carries one encoded byte, msb first, with
//    last_byte set on the final byte of the value's encoding
//  - each value yields 1, 2, 3, 5 or 9 bytes depending on its range
//  - with the block empty the first byte passes through the queue and then
//    the output register before it is valid on rsp
//  - throughput: one byte per cycle on rsp while rsp_ready is high; a value
//    holds the output until its last byte has gone out, set by the single
//    output byte register
//  - the front end classifies and queues values while the back end is
//    still shifting out earlier ones; req_ready drops only when the
//    queue is full
//  - reset empties the queue and the output register; no clearing pass
//  - when rsp_ready is low the current byte holds and the queue fills,
//    then req_ready goes low
module prefix_varint_encoder #(
   parameter int unsigned QUEUE_DEPTH = pve_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pve_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pve_pkg::rsp_type rsp_item
);

`include "prefix_varint_encoder_defines.svh"

   // front end to queue
   logic               push;
   pve_pkg::ent_type   push_ent;
   // queue to back end
   logic               pop;
   pve_pkg::ent_type   pop_ent;
   pve_pkg::qstat_type q_stat;

   // classify incoming values into prefix and byte count
   pve_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_full    (q_stat.full),
      .push      (push),
      .push_ent  (push_ent)
   );

   // decouples the front end from output stalls
   pve_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_ent (push_ent),
      .pop      (pop),
      .pop_ent  (pop_ent),
      .stat     (q_stat)
   );

   // byte serializer and output register
   pve_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_ent     (pop_ent),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // a full queue always holds something
   `PVE_ASSERT_NOW(a_full_not_empty, clock, reset, q_stat.full, q_stat.valid)
   // a transfer into an empty block shows up in the queue next cycle
   `PVE_ASSERT_NEXT(a_accept_queues, clock, reset,
      req_valid && req_ready && !q_stat.valid && !rsp_valid, q_stat.valid)
   // a byte that is not the last is always followed by another
   `PVE_ASSERT_NEXT(a_more_bytes, clock, reset,
      rsp_valid && rsp_ready && !rsp_item.last_byte, rsp_valid)
   // the last byte with nothing queued leaves the output empty
   `PVE_ASSERT_NEXT(a_drain_idle, clock, reset,
      rsp_valid && rsp_ready && rsp_item.last_byte && !q_stat.valid, !rsp_valid)

endmodule
